/* hdl/fpa2_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point arctan2 core.
// No dependencies; imported by every module under hdl/.
package fpa2_pkg;

	// Field widths
	localparam int CoordW = 16;
	localparam int AngleW = 17;

	// Quotient magnitude covers 0..2^14, one quotient bit per divider stage
	localparam int QuoW      = 15;
	localparam int DivStages = QuoW;

	// Polynomial: eight coefficients, seven multiply-add steps
	localparam int PolyTerms = 8;
	localparam int BW        = 18;

	// Input register, divider, square stage, multiply-add steps, final stage
	localparam int PipeLat = 1 + DivStages + 1 + (PolyTerms - 1) + 1;

	// Angle offsets in units of 1/65536 turn
	localparam logic [AngleW-1:0] ANG_ZERO    = 17'h00000;
	localparam logic [AngleW-1:0] ANG_QUARTER = 17'h04000;
	localparam logic [AngleW-1:0] ANG_HALF    = 17'h08000;
	localparam logic [AngleW-1:0] ANG_3QUART  = 17'h0C000;
	localparam logic [AngleW-1:0] ANG_FULL    = 17'h10000;

	// Arctan polynomial coefficients, highest order first
	localparam logic signed [BW-1:0] POLY_COEF [PolyTerms] = '{
		18'sh000A9, 18'sh00390, 18'sh0091C, 18'sh00FB6,
		18'sh016AA, 18'sh02081, 18'sh03651, 18'sh0A2F9
	};

	// Per-item sideband that travels with the quotient
	typedef struct packed {
		logic              axis;        // x or y is zero, angle is fixed
		logic [AngleW-1:0] axis_angle;
		logic              xmaj;        // ratio is y / x
		logic              xneg;
		logic              yneg;
		logic              qneg;        // signed ratio is negative
	} fpa2_side_t;

endpackage

/* hdl/fpa2_divider.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: (num * 2^14) / den, one quotient bit per stage.
// Depends on fpa2_pkg; requires num <= den.
module fpa2_divider import fpa2_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [CoordW-1:0]  num,
	input  logic [CoordW-1:0]  den,
	input  fpa2_side_t         in_side,
	output logic               out_vld,
	output logic [QuoW-1:0]    quo,
	output fpa2_side_t         out_side
);

	logic              vld_s  [DivStages];
	logic [CoordW-1:0] rem_s  [DivStages];
	logic [CoordW-1:0] den_s  [DivStages];
	logic [QuoW-1:0]   quo_s  [DivStages];
	fpa2_side_t        side_s [DivStages];

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		logic [CoordW:0]   cand;
		logic [CoordW-1:0] den_in;
		logic [QuoW-1:0]   quo_in;
		logic              vld_in;
		fpa2_side_t        side_in;
		logic              ge;

		// Select the partial remainder: the numerator first, then shift in a zero
		if (k == 0) begin : g_first
			assign cand    = {1'b0, num};
			assign den_in  = den;
			assign quo_in  = '0;
			assign vld_in  = in_vld;
			assign side_in = in_side;
		end else begin : g_next
			assign cand    = {rem_s[k-1], 1'b0};
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign vld_in  = vld_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign ge = cand >= {1'b0, den_in};

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		// Subtract when the divisor fits and append the quotient bit
		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? CoordW'(cand - {1'b0, den_in}) : cand[CoordW-1:0];
			den_s[k]  <= den_in;
			quo_s[k]  <= {quo_in[QuoW-2:0], ge};
			side_s[k] <= side_in;
		end
	end

	assign out_vld  = vld_s[DivStages-1];
	assign quo      = quo_s[DivStages-1];
	assign out_side = side_s[DivStages-1];

endmodule

/* hdl/fpa2_poly.sv */
`timescale 1ns / 1ps
// Arctan polynomial pipeline and quadrant correction, one multiplier per stage.
// Depends on fpa2_pkg; fed by fpa2_divider.
module fpa2_poly import fpa2_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [QuoW-1:0]   qmag,
	input  fpa2_side_t        in_side,
	output logic              done,
	output logic [AngleW-1:0] angle
);

	localparam int Steps = PolyTerms;

	logic                     vld_s  [Steps];
	logic signed [CoordW-1:0] q_s    [Steps];
	logic signed [CoordW-1:0] a_s    [Steps];
	logic signed [BW-1:0]     b_s    [Steps];
	fpa2_side_t               side_s [Steps];

	// Square stage: a = -floor(q*q / 2^14), q signed from the magnitude
	logic [2*QuoW-1:0]        sq;
	logic [CoordW-1:0]        sq_hi;
	logic signed [CoordW-1:0] q_in;

	assign sq    = (2*QuoW)'(qmag) * (2*QuoW)'(qmag);
	assign sq_hi = CoordW'(sq >> 14);
	assign q_in  = in_side.qneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		q_s[0]    <= q_in;
		a_s[0]    <= -$signed(sq_hi);
		b_s[0]    <= POLY_COEF[0];
		side_s[0] <= in_side;
	end

	// Multiply-add steps: b = floor(b*a / 2^14) + coefficient
	for (genvar k = 1; k < Steps; k++) begin : g_step
		logic signed [BW+CoordW-1:0] prod;
		logic signed [BW+CoordW-1:0] prod_sh;

		assign prod    = (BW+CoordW)'(b_s[k-1]) * (BW+CoordW)'(a_s[k-1]);
		assign prod_sh = prod >>> 14;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			b_s[k]    <= prod_sh[BW-1:0] + POLY_COEF[k];
			q_s[k]    <= q_s[k-1];
			a_s[k]    <= a_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	// Final stage: p = floor(q*b / 2^16), then apply the quadrant offset
	logic signed [BW+CoordW-1:0] pprod;
	logic signed [BW+CoordW-1:0] pprod_sh;
	logic [AngleW-1:0]           p17;
	logic [AngleW-1:0]           angle_d;
	fpa2_side_t                  sd;

	assign pprod    = (BW+CoordW)'(q_s[Steps-1]) * (BW+CoordW)'(b_s[Steps-1]);
	assign pprod_sh = pprod >>> 16;
	assign p17      = pprod_sh[AngleW-1:0];
	assign sd       = side_s[Steps-1];

	always_comb begin
		priority if (sd.axis) begin
			angle_d = sd.axis_angle;
		end else if (sd.xmaj && sd.xneg) begin
			angle_d = p17 + ANG_HALF;
		end else if (sd.xmaj) begin
			angle_d = p17 + (sd.yneg ? ANG_FULL : ANG_ZERO);
		end else begin
			angle_d = (ANG_QUARTER + (sd.yneg ? ANG_HALF : ANG_ZERO)) - p17;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[Steps-1];
		end
	end

	always_ff @(posedge clk) begin
		angle <= angle_d;
	end

endmodule

/* hdl/fixed_point_arctan2_core.sv */
`timescale 1ns / 1ps
// Top level of the fixed-point arctan2 core: input stage, divider, polynomial.
// Depends on fpa2_pkg, fpa2_divider and fpa2_poly.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  input    | start && !busy      | coord_x[15:0] s, coord_y[15:0] s
//  result   | done (one cycle)    | angle[16:0] u, 0x10000 is one turn
//
// Pipeline: one input register, 15 divider stages (one quotient bit each),
// a squaring stage, seven multiply-add stages and a final stage.
// A new item is taken every cycle; busy is always low.
// Reset clears only the valid bits; the datapath holds no state between items.
// The receiver cannot stall, so every result appears exactly once on done.
module fixed_point_arctan2_core import fpa2_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [CoordW-1:0] coord_x,
	input  logic signed [CoordW-1:0] coord_y,
	output logic                     done,
	output logic [AngleW-1:0]        angle
);

	assign busy = 1'b0;

	// Classify the input: magnitudes, major axis, axis cases
	logic [CoordW-1:0] ax;
	logic [CoordW-1:0] ay;
	logic              xmaj;
	fpa2_side_t        side_d;

	assign ax   = coord_x[CoordW-1] ? CoordW'(-coord_x) : coord_x;
	assign ay   = coord_y[CoordW-1] ? CoordW'(-coord_y) : coord_y;
	assign xmaj = (ax > ay) || ((ax == ay) && !(coord_x[CoordW-1] && coord_y[CoordW-1]));

	always_comb begin
		side_d.axis       = (coord_x == '0) || (coord_y == '0);
		side_d.xmaj       = xmaj;
		side_d.xneg       = coord_x[CoordW-1];
		side_d.yneg       = coord_y[CoordW-1];
		side_d.qneg       = coord_x[CoordW-1] ^ coord_y[CoordW-1];
		priority if (coord_y == '0) begin
			side_d.axis_angle = coord_x[CoordW-1] ? ANG_HALF : ANG_ZERO;
		end else begin
			side_d.axis_angle = coord_y[CoordW-1] ? ANG_3QUART : ANG_QUARTER;
		end
	end

	// Input register
	logic              vld_s1;
	logic [CoordW-1:0] num_s1;
	logic [CoordW-1:0] den_s1;
	fpa2_side_t        side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		num_s1  <= xmaj ? ay : ax;
		den_s1  <= xmaj ? ax : ay;
		side_s1 <= side_d;
	end

	// Ratio of minor to major magnitude, 1.14
	logic            div_vld;
	logic [QuoW-1:0] div_quo;
	fpa2_side_t      div_side;

	fpa2_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.num      (num_s1),
		.den      (den_s1),
		.in_side  (side_s1),
		.out_vld  (div_vld),
		.quo      (div_quo),
		.out_side (div_side)
	);

	// Polynomial and quadrant correction
	fpa2_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (div_vld),
		.qmag    (div_quo),
		.in_side (div_side),
		.done    (done),
		.angle   (angle)
	);

	// Every accepted item leaves after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(PipeLat) done)
		else $error("item did not complete after pipeline latency");

	// No result without an accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(PipeLat) !done)
		else $error("result strobe without an accepted item");

	// Angle never exceeds one full turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle <= ANG_FULL))
		else $error("angle out of range");

	// Positive x axis maps to zero
	a_pos_x_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (coord_y == '0) && !coord_x[CoordW-1])
		|-> ##(PipeLat) (angle == ANG_ZERO))
		else $error("positive x axis did not give zero angle");

endmodule
